>>> design/lpkr_pkg.sv
// Package for the last pressed key resolver: types, constants, button lookup.
`default_nettype none

package lpkr_pkg;

    localparam int KEY_W        = 7;
    localparam int NUM_BUTTONS  = 7;
    localparam int BTN_W        = 3;
    localparam int DEF_MAX_HELD = 8;
    localparam int ADDR_W       = 5;
    localparam int DATA_W       = 32;

    typedef enum logic [BTN_W-1:0] {
        BTN_LEFT   = 3'd0,
        BTN_UP     = 3'd1,
        BTN_RIGHT  = 3'd2,
        BTN_DOWN   = 3'd3,
        BTN_CANCEL = 3'd4,
        BTN_PAUSE  = 3'd5,
        BTN_SELECT = 3'd6,
        BTN_NONE   = 3'd7
    } t_button;

    typedef enum logic {
        OP_PRESS   = 1'b0,
        OP_RELEASE = 1'b1
    } t_op;

    typedef logic [NUM_BUTTONS-1:0][KEY_W-1:0] t_key_map;

    // Register i holds the key of button i
    localparam t_key_map KEY_MAP_RESET = {
        7'd58, 7'd15, 7'd16, 7'd18, 7'd3, 7'd22, 7'd0
    };

    typedef struct packed {
        logic             operation;
        logic [KEY_W-1:0] key_code;
    } t_key_event;

    typedef struct packed {
        logic             direction_valid;
        logic [1:0]       direction;
        logic             selection_valid;
        logic [1:0]       selection;
        logic             any_valid;
        logic [BTN_W-1:0] any_button;
    } t_key_result;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SHIFT,
        ST_RESOLVE,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic load;
        logic step;
        logic shift;
        logic res_init;
        logic res_step;
    } t_dp_cmd;

    typedef struct packed {
        logic idx_end;
        logic match;
        logic is_press;
    } t_dp_sts;

    // Lowest-numbered button wins when mappings collide
    function automatic t_button button_of(input logic [KEY_W-1:0] key, input t_key_map map);
        t_button b;
        b = BTN_NONE;
        for (int i = NUM_BUTTONS - 1; i >= 0; i--) begin
            if (map[i] == key) begin
                b = t_button'(BTN_W'(i));
            end
        end
        return b;
    endfunction

endpackage

`default_nettype wire

>>> design/last_pressed_key_resolver.sv
// Top level of the last pressed key resolver.
//
// Usage: drive i_event (operation, key_code) and raise start; the word is
// taken at the clock edge where start is high and busy is low. busy then
// stays high until the result word has been shown. The result appears on
// o_result when o_strobe is high for exactly one cycle; the receiver cannot
// stall it and must take it in that cycle.
// Sequence from accept to strobe: the list is walked once to find or
// compact the key (one entry per cycle, stopping early when a pressed key
// is already held), a shift step pushes the key of a new press, then the
// list is walked again to resolve buttons, one entry per cycle, and the
// result is strobed. A new word can be taken the cycle after strobe.
// The key map sits in seven APB registers at byte addresses 0, 4, .. 24;
// write them only while busy is low. Reset empties the held list and
// loads the default key map; list entries are not cleared.
`default_nettype none

module last_pressed_key_resolver #(
    parameter int MAX_HELD = lpkr_pkg::DEF_MAX_HELD
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        start,
    output logic                             busy,
    input  wire lpkr_pkg::t_key_event        i_event,
    output logic                             o_strobe,
    output lpkr_pkg::t_key_result            o_result,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [lpkr_pkg::ADDR_W-1:0] paddr,
    input  wire logic [lpkr_pkg::DATA_W-1:0] pwdata,
    output logic      [lpkr_pkg::DATA_W-1:0] prdata,
    output logic                             pready
);
    import lpkr_pkg::*;

    t_key_map w_map;
    t_dp_cmd  w_cmd;
    t_dp_sts  w_sts;

    lpkr_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_map   (w_map)
    );

    lpkr_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_sts    (w_sts),
        .o_cmd    (w_cmd),
        .o_busy   (busy),
        .o_strobe (o_strobe)
    );

    lpkr_dp #(
        .MAX_HELD (MAX_HELD)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_event  (i_event),
        .i_map    (w_map),
        .i_cmd    (w_cmd),
        .o_sts    (w_sts),
        .o_result (o_result)
    );

    a_strobe_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> busy)
        else $error("result strobe outside of a busy window");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (busy && !o_strobe))
        else $error("accepted word did not raise busy");

    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |=> !o_strobe)
        else $error("result strobe held longer than one cycle");

    a_any_consistent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (o_result.any_valid ==
                      (o_result.direction_valid || o_result.selection_valid)))
        else $error("any button flag disagrees with class flags");

    a_empty_codes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_result.any_valid) |->
            (o_result.any_button == '0 && o_result.direction == '0 &&
             o_result.selection == '0))
        else $error("button code set without a matching key");

endmodule

`default_nettype wire

>>> design/lpkr_regs.sv
// Key map configuration registers behind the APB-style port.
`default_nettype none

module lpkr_regs (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [lpkr_pkg::ADDR_W-1:0] paddr,
    input  wire logic [lpkr_pkg::DATA_W-1:0] pwdata,
    output logic      [lpkr_pkg::DATA_W-1:0] prdata,
    output logic                            pready,
    output lpkr_pkg::t_key_map              o_map
);
    import lpkr_pkg::*;

    t_key_map         r_map;
    logic [BTN_W-1:0] w_index;

    assign w_index = paddr[ADDR_W-1:2];
    assign pready  = 1'b1;
    assign o_map   = r_map;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_map <= KEY_MAP_RESET;
        end else if (psel && penable && pwrite && (w_index < BTN_W'(NUM_BUTTONS))) begin
            r_map[w_index] <= pwdata[KEY_W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (w_index < BTN_W'(NUM_BUTTONS)) begin
            prdata[KEY_W-1:0] = r_map[w_index];
        end
    end

endmodule

`default_nettype wire

>>> design/lpkr_ctrl.sv
// Controller state machine: sequences scan, shift, resolve and result strobe.
`default_nettype none

module lpkr_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire lpkr_pkg::t_dp_sts i_sts,
    output lpkr_pkg::t_dp_cmd      o_cmd,
    output logic                   o_busy,
    output logic                   o_strobe
);
    import lpkr_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_start) n_state = ST_SCAN;
            end
            ST_SCAN: begin
                if (i_sts.idx_end) begin
                    n_state = i_sts.is_press ? ST_SHIFT : ST_RESOLVE;
                end else if (i_sts.is_press && i_sts.match) begin
                    n_state = ST_RESOLVE;
                end
            end
            ST_SHIFT:   n_state = ST_RESOLVE;
            ST_RESOLVE: begin
                if (i_sts.idx_end) n_state = ST_EMIT;
            end
            ST_EMIT:    n_state = ST_IDLE;
            default:    n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd    = '0;
        o_busy   = 1'b1;
        o_strobe = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_busy     = 1'b0;
                o_cmd.load = i_start;
            end
            ST_SCAN: begin
                // Already held on press: go resolve; end of list: shift on press, else resolve
                if (i_sts.idx_end) begin
                    o_cmd.res_init = !i_sts.is_press;
                end else if (i_sts.is_press && i_sts.match) begin
                    o_cmd.res_init = 1'b1;
                end else begin
                    o_cmd.step = 1'b1;
                end
            end
            ST_SHIFT: begin
                o_cmd.shift    = 1'b1;
                o_cmd.res_init = 1'b1;
            end
            ST_RESOLVE: begin
                o_cmd.res_step = !i_sts.idx_end;
            end
            ST_EMIT: begin
                o_strobe = 1'b1;
            end
            default: begin
                o_busy = 1'b1;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> design/lpkr_dp.sv
// Datapath: held-key list, walk pointers and button resolution registers.
`default_nettype none

module lpkr_dp #(
    parameter int MAX_HELD = lpkr_pkg::DEF_MAX_HELD
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire lpkr_pkg::t_key_event i_event,
    input  wire lpkr_pkg::t_key_map   i_map,
    input  wire lpkr_pkg::t_dp_cmd    i_cmd,
    output lpkr_pkg::t_dp_sts         o_sts,
    output lpkr_pkg::t_key_result     o_result
);
    import lpkr_pkg::*;

    localparam int CNT_W = $clog2(MAX_HELD + 1);
    localparam int IDX_W = (MAX_HELD > 1) ? $clog2(MAX_HELD) : 1;

    logic [KEY_W-1:0] r_held [MAX_HELD];
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] r_idx;
    logic [CNT_W-1:0] r_wr;
    logic [KEY_W-1:0] r_key;
    t_op              r_op;
    t_key_result      r_res;

    logic [KEY_W-1:0] w_cur;
    t_button          w_btn;

    assign w_cur = r_held[r_idx[IDX_W-1:0]];
    assign w_btn = button_of(w_cur, i_map);

    assign o_sts.idx_end  = (r_idx == r_count);
    assign o_sts.match    = (w_cur == r_key);
    assign o_sts.is_press = (r_op == OP_PRESS);
    assign o_result       = r_res;

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_idx   <= '0;
            r_wr    <= '0;
            r_op    <= OP_PRESS;
        end else begin
            if (i_cmd.load) begin
                r_op  <= t_op'(i_event.operation);
                r_idx <= '0;
                r_wr  <= '0;
            end else if (i_cmd.step) begin
                r_idx <= r_idx + 1'b1;
                if (r_op == OP_RELEASE && w_cur != r_key) begin
                    r_wr <= r_wr + 1'b1;
                end
            end else if (i_cmd.res_init) begin
                r_idx <= '0;
            end else if (i_cmd.res_step) begin
                r_idx <= r_idx + 1'b1;
            end

            if (i_cmd.shift) begin
                if (r_count != CNT_W'(MAX_HELD)) r_count <= r_count + 1'b1;
            end else if (i_cmd.res_init && r_op == OP_RELEASE) begin
                r_count <= r_wr;
            end
        end
    end

    // List storage: compact on release, push front on new press
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_key <= i_event.key_code;
        end
        if (i_cmd.step && r_op == OP_RELEASE && w_cur != r_key) begin
            r_held[r_wr[IDX_W-1:0]] <= w_cur;
        end
        if (i_cmd.shift) begin
            for (int j = MAX_HELD - 1; j > 0; j--) begin
                r_held[j] <= r_held[j-1];
            end
            r_held[0] <= r_key;
        end
    end

    // Front-first scan: keep the first hit of each class
    always_ff @(posedge i_clk) begin
        if (i_cmd.res_init) begin
            r_res <= '0;
        end else if (i_cmd.res_step && w_btn != BTN_NONE) begin
            if (!r_res.any_valid) begin
                r_res.any_valid  <= 1'b1;
                r_res.any_button <= w_btn;
            end
            if (w_btn < BTN_CANCEL) begin
                if (!r_res.direction_valid) begin
                    r_res.direction_valid <= 1'b1;
                    r_res.direction       <= w_btn[1:0];
                end
            end else if (!r_res.selection_valid) begin
                r_res.selection_valid <= 1'b1;
                r_res.selection       <= 2'(w_btn - BTN_CANCEL);
            end
        end
    end

endmodule

`default_nettype wire
